@@ sv/qfp_pkg.sv @@
// qfp_pkg: shared types and constants of the quic frame parser
// no dependencies; imported by every module of the block
`default_nettype none
package qfp_pkg;

  localparam int unsigned VAL_W = 62;

  // result kinds
  localparam logic [1:0] RK_FIELD    = 2'd0;
  localparam logic [1:0] RK_BODY     = 2'd1;
  localparam logic [1:0] RK_BODILESS = 2'd2;
  localparam logic [1:0] RK_ERROR    = 2'd3;

  // error kinds
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TRUNC   = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN = 2'd2;
  localparam logic [1:0] ERR_CID_LEN = 2'd3;

  // frame type codes
  localparam logic [5:0] FT_PADDING   = 6'h00;
  localparam logic [5:0] FT_PING      = 6'h01;
  localparam logic [5:0] FT_ACK       = 6'h02;
  localparam logic [5:0] FT_ACK_ECN   = 6'h03;
  localparam logic [5:0] FT_RESET     = 6'h04;
  localparam logic [5:0] FT_STOP      = 6'h05;
  localparam logic [5:0] FT_CRYPTO    = 6'h06;
  localparam logic [5:0] FT_TOKEN     = 6'h07;
  localparam logic [5:0] FT_MAX_SD    = 6'h11;
  localparam logic [5:0] FT_SD_BLK    = 6'h15;
  localparam logic [5:0] FT_NEW_CID   = 6'h18;
  localparam logic [5:0] FT_PATH_CH   = 6'h1A;
  localparam logic [5:0] FT_PATH_RSP  = 6'h1B;
  localparam logic [5:0] FT_CLOSE_T   = 6'h1C;
  localparam logic [5:0] FT_CLOSE_A   = 6'h1D;
  localparam logic [5:0] FT_HS_DONE   = 6'h1E;
  localparam logic [5:0] FT_DGRAM     = 6'h30;
  localparam logic [5:0] FT_DGRAM_LEN = 6'h31;

  localparam logic [7:0] MAX_CID_RESET = 8'd20;
  localparam logic [VAL_W-1:0] TOKEN_LEN     = VAL_W'(16);
  localparam logic [VAL_W-1:0] PATH_DATA_LEN = VAL_W'(8);

  // parse phase, one-hot
  typedef enum logic [4:0] {
    PH_TYPE   = 5'b00001,
    PH_FIELD  = 5'b00010,
    PH_CIDLEN = 5'b00100,
    PH_BODY   = 5'b01000,
    PH_TAIL   = 5'b10000
  } phase_t;

  // one queued byte beat
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last;
  } item_t;

endpackage
`default_nettype wire

@@ sv/qfp_front.sv @@
// qfp_front: input side, takes byte beats into a two-entry queue
// depends on qfp_pkg
`default_nettype none
module qfp_front
  import qfp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic [7:0] byte_value,
  input  wire logic  last_of_packet,
  output logic       q_valid,
  output item_t      q_item,
  input  wire logic  q_pop
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{byte_value: byte_value, last: last_of_packet};
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/qfp_back.sv @@
// qfp_back: frame parser state machine and output register
// depends on qfp_pkg; fed by qfp_front
`default_nettype none
module qfp_back
  import qfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [5:0]       frame_code,
  output logic [3:0]       field_slot,
  output logic [VAL_W-1:0] field_value,
  output logic [1:0]       error_kind,
  output logic             frame_end,
  output logic             packet_end
);

  logic [7:0]       max_cid;
  phase_t           ph, ph_next;
  logic [5:0]       ct, ct_next;
  logic [VAL_W-1:0] acc, acc_next;
  logic [2:0]       vbl, vbl_next;
  logic [VAL_W-1:0] body, body_next;
  logic [VAL_W-1:0] pairs, pairs_next;
  logic [3:0]       slot, slot_next;
  logic             disc, disc_next;

  logic [VAL_W-1:0] tv_acc;
  logic [2:0]       tv_vbl;
  logic [7:0]       b;
  logic             last;

  logic             have, done, clr;
  logic [1:0]       kind, err;
  logic [3:0]       oslot;
  logic [VAL_W-1:0] val;
  logic [5:0]       ft;
  logic             go_f, go_b, go_t, go_c;
  logic [3:0]       sl;
  logic [VAL_W-1:0] blen, pdec, bdec;

  assign b     = q_item.byte_value;
  assign last  = q_item.last;
  assign q_pop = q_valid && (!out_valid || !out_stall);

  // varint byte assembly
  always_comb begin
    if (vbl == 3'd0) begin
      tv_acc = {56'd0, b[5:0]};
      unique case (b[7:6])
        2'd0: tv_vbl = 3'd0;
        2'd1: tv_vbl = 3'd1;
        2'd2: tv_vbl = 3'd3;
        default: tv_vbl = 3'd7;
      endcase
    end else begin
      tv_acc = {acc[VAL_W-9:0], b};
      tv_vbl = vbl - 3'd1;
    end
  end

  // per-byte parse step
  always_comb begin
    ph_next    = ph;
    ct_next    = ct;
    acc_next   = acc;
    vbl_next   = vbl;
    body_next  = body;
    pairs_next = pairs;
    slot_next  = slot;
    disc_next  = disc;
    have = 1'b0; done = 1'b0; clr = 1'b0;
    kind = RK_FIELD; err = ERR_NONE; oslot = 4'd0; val = '0; ft = 6'd0;
    go_f = 1'b0; go_b = 1'b0; go_t = 1'b0; go_c = 1'b0;
    sl = 4'd0; blen = '0;
    pdec = (pairs != '0) ? pairs - VAL_W'(1) : pairs;
    bdec = (body != '0) ? body - VAL_W'(1) : body;

    if (disc) begin
      if (last) begin
        disc_next = 1'b0;
        clr = 1'b1;
      end
    end else begin
      unique case (ph)
        PH_TYPE: begin
          if (vbl == 3'd0) ct_next = 6'd0;
          acc_next = tv_acc;
          vbl_next = tv_vbl;
          if (tv_vbl == 3'd0) begin
            ct_next = tv_acc[5:0];
            if (tv_acc == VAL_W'(FT_PADDING) || tv_acc == VAL_W'(FT_PING) ||
                tv_acc == VAL_W'(FT_HS_DONE)) begin
              done = 1'b1;
            end else if (tv_acc == VAL_W'(FT_PATH_CH) ||
                         tv_acc == VAL_W'(FT_PATH_RSP)) begin
              go_b = 1'b1; sl = 4'd0; blen = PATH_DATA_LEN;
            end else if (tv_acc == VAL_W'(FT_DGRAM)) begin
              go_t = 1'b1; sl = 4'd0;
            end else if (tv_acc <= VAL_W'(FT_CLOSE_A) ||
                         tv_acc == VAL_W'(FT_DGRAM_LEN)) begin
              go_f = 1'b1; sl = 4'd0;
            end else begin
              err = ERR_UNKNOWN;
            end
          end
        end
        PH_FIELD: begin
          acc_next = tv_acc;
          vbl_next = tv_vbl;
          if (tv_vbl == 3'd0) begin
            have  = 1'b1;
            oslot = slot;
            val   = tv_acc;
            // layout of what follows this field
            if (ct >= 6'h08 && ct <= 6'h0F) begin
              if (slot == 4'd0 && ct[2]) begin
                go_f = 1'b1; sl = 4'd1;
              end else if (slot <= 4'd1 && ct[1]) begin
                go_f = 1'b1; sl = 4'd2;
              end else if (slot <= 4'd1) begin
                go_t = 1'b1; sl = 4'd3;
              end else begin
                go_b = 1'b1; sl = 4'd3; blen = tv_acc;
              end
            end else begin
              unique case (ct)
                FT_ACK, FT_ACK_ECN: begin
                  if (slot <= 4'd1) begin
                    go_f = 1'b1; sl = slot + 4'd1;
                  end else if (slot == 4'd2) begin
                    pairs_next = tv_acc;
                    go_f = 1'b1; sl = 4'd3;
                  end else if (slot == 4'd3 || slot == 4'd5) begin
                    if (slot == 4'd5) pairs_next = pdec;
                    if ((slot == 4'd5 ? pdec : pairs) != '0) begin
                      go_f = 1'b1; sl = 4'd4;
                    end else if (ct == FT_ACK_ECN) begin
                      go_f = 1'b1; sl = 4'd6;
                    end else begin
                      done = 1'b1;
                    end
                  end else if (slot == 4'd4) begin
                    go_f = 1'b1; sl = 4'd5;
                  end else if (slot < 4'd8) begin
                    go_f = 1'b1; sl = slot + 4'd1;
                  end else begin
                    done = 1'b1;
                  end
                end
                FT_RESET: begin
                  if (slot < 4'd2) begin
                    go_f = 1'b1; sl = slot + 4'd1;
                  end else done = 1'b1;
                end
                FT_STOP, FT_MAX_SD, FT_SD_BLK: begin
                  if (slot == 4'd0) begin
                    go_f = 1'b1; sl = 4'd1;
                  end else done = 1'b1;
                end
                FT_CRYPTO: begin
                  if (slot == 4'd0) begin
                    go_f = 1'b1; sl = 4'd1;
                  end else begin
                    go_b = 1'b1; sl = 4'd2; blen = tv_acc;
                  end
                end
                FT_TOKEN, FT_DGRAM_LEN: begin
                  go_b = 1'b1; sl = 4'd1; blen = tv_acc;
                end
                FT_NEW_CID: begin
                  if (slot == 4'd0) begin
                    go_f = 1'b1; sl = 4'd1;
                  end else begin
                    go_c = 1'b1; sl = 4'd2;
                  end
                end
                FT_CLOSE_T: begin
                  if (slot < 4'd2) begin
                    go_f = 1'b1; sl = slot + 4'd1;
                  end else begin
                    go_b = 1'b1; sl = 4'd3; blen = tv_acc;
                  end
                end
                FT_CLOSE_A: begin
                  if (slot == 4'd0) begin
                    go_f = 1'b1; sl = 4'd2;
                  end else begin
                    go_b = 1'b1; sl = 4'd3; blen = tv_acc;
                  end
                end
                default: done = 1'b1;
              endcase
            end
          end
        end
        PH_CIDLEN: begin
          have  = 1'b1;
          oslot = slot;
          val   = {54'd0, b};
          if (b > max_cid) begin
            err = ERR_CID_LEN;
          end else if (b == 8'd0) begin
            go_b = 1'b1; sl = 4'd4; blen = TOKEN_LEN;
          end else begin
            go_b = 1'b1; sl = 4'd3; blen = {54'd0, b};
          end
        end
        PH_BODY: begin
          have      = 1'b1;
          kind      = RK_BODY;
          oslot     = slot;
          val       = {54'd0, b};
          body_next = bdec;
          if (bdec == '0) begin
            if (ct == FT_NEW_CID && slot == 4'd3) begin
              go_b = 1'b1; sl = 4'd4; blen = TOKEN_LEN;
            end else done = 1'b1;
          end
        end
        PH_TAIL: begin
          have  = 1'b1;
          kind  = RK_BODY;
          oslot = slot;
          val   = {54'd0, b};
        end
        default: clr = 1'b1;
      endcase

      // apply the chosen next step
      if (go_f) begin
        ph_next = PH_FIELD; slot_next = sl; vbl_next = 3'd0;
      end
      if (go_t) begin
        ph_next = PH_TAIL; slot_next = sl;
      end
      if (go_c) begin
        ph_next = PH_CIDLEN; slot_next = sl;
      end
      if (go_b) begin
        if (blen == '0) begin
          done = 1'b1;
        end else begin
          ph_next = PH_BODY; slot_next = sl; body_next = blen;
        end
      end

      // packet end: tail frames close, anything else open is truncated
      if (err == ERR_NONE && !done && ph_next == PH_TAIL && last) done = 1'b1;
      if (err == ERR_NONE && last && !done) err = ERR_TRUNC;

      ft = ct_next;
      if (err != ERR_NONE) begin
        have = 1'b1; kind = RK_ERROR; oslot = 4'd0; val = '0;
        disc_next = !last;
        clr = 1'b1;
      end else begin
        if (done && !have) begin
          have = 1'b1; kind = RK_BODILESS; oslot = 4'd0; val = '0;
        end
        if (done || last) clr = 1'b1;
      end
    end

    if (clr) begin
      ph_next    = PH_TYPE;
      ct_next    = 6'd0;
      acc_next   = '0;
      vbl_next   = 3'd0;
      body_next  = '0;
      pairs_next = '0;
      slot_next  = 4'd0;
    end
  end

  // parse state and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cid <= MAX_CID_RESET;
      ph      <= PH_TYPE;
      ct      <= 6'd0;
      acc     <= '0;
      vbl     <= 3'd0;
      body    <= '0;
      pairs   <= '0;
      slot    <= 4'd0;
      disc    <= 1'b0;
    end else begin
      if (cfg_we) max_cid <= cfg_data;
      if (q_pop) begin
        ph    <= ph_next;
        ct    <= ct_next;
        acc   <= acc_next;
        vbl   <= vbl_next;
        body  <= body_next;
        pairs <= pairs_next;
        slot  <= slot_next;
        disc  <= disc_next;
      end
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= have;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && have) begin
      result_kind <= kind;
      frame_code  <= ft;
      field_slot  <= oslot;
      field_value <= val;
      error_kind  <= err;
      frame_end   <= (err != ERR_NONE) || done;
      packet_end  <= (err != ERR_NONE) || last;
    end
  end

endmodule
`default_nettype wire

@@ sv/quic_frame_parser.sv @@
// quic_frame_parser: top level, byte queue front and frame parser back
// depends on qfp_pkg, qfp_front, qfp_back
//
// usage
//   input channel: one payload byte per beat (byte_value, last_of_packet),
//   in_valid / in_stall. output channel: at most one result beat per input
//   byte, out_valid / out_stall. cfg_we with cfg_data writes the largest
//   accepted connection ID length (reset value 20); the user is to write it
//   only while the block is idle, which the block itself does not enforce.
//   throughput is one byte per cycle: the back end parses one queued byte per
//   cycle whenever its output register is empty or being taken.
//   a byte is queued when accepted and then parsed into the output register.
//   bytes that only extend a varint, or carry the type of a frame with fields
//   or a body, give no result unless they raise an error or close the frame.
//   reset (rst, synchronous) empties the queue, drops any result held and
//   returns the parser to expecting a frame type.
//   when the receiver stalls, the result holds; the queue takes up to two
//   further bytes before in_stall rises.
`default_nettype none
module quic_frame_parser
  import qfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_of_packet,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       result_kind,
  output logic [5:0]       frame_code,
  output logic [3:0]       field_slot,
  output logic [VAL_W-1:0] field_value,
  output logic [1:0]       error_kind,
  output logic             frame_end,
  output logic             packet_end
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  qfp_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .byte_value(byte_value), .last_of_packet(last_of_packet),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  qfp_back u_back (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .frame_code(frame_code),
    .field_slot(field_slot), .field_value(field_value),
    .error_kind(error_kind), .frame_end(frame_end),
    .packet_end(packet_end)
  );

endmodule
`default_nettype wire

@@ sv/qfp_checker.sv @@
// qfp_checker: port-level assertions on the quic frame parser
// depends on qfp_pkg; bound to quic_frame_parser
`default_nettype none
module qfp_checker
  import qfp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  result_kind,
  input wire logic [3:0]  field_slot,
  input wire logic [1:0]  error_kind,
  input wire logic        frame_end,
  input wire logic        packet_end
);

  // no result beat straight after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat after reset");

  // an error beat closes both frame and packet at slot zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == RK_ERROR) |->
      (frame_end && packet_end && field_slot == 4'd0 && error_kind != ERR_NONE))
    else $error("malformed error beat");

  // only error beats carry an error code
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind != RK_ERROR) |-> error_kind == ERR_NONE)
    else $error("error code on non-error beat");

  // a stalled beat stays valid
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled beat dropped");

endmodule

bind quic_frame_parser qfp_checker u_qfp_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .result_kind(result_kind), .field_slot(field_slot),
  .error_kind(error_kind), .frame_end(frame_end), .packet_end(packet_end)
);
`default_nettype wire
